[rtl/lag_pkg.sv]
// ----------------------------------------------------------------------------
// lag_pkg
// Shared types and constants of the life automaton grid core: operation
// codes, controller states, the memory command bundle and rule counts.
// ----------------------------------------------------------------------------
package lag_pkg;

    // Grid size bounds and field widths
    localparam int DIM_DEFAULT = 32;
    localparam int DIM_LIMIT   = 64;
    localparam int ROW_IDX_W   = 5;
    localparam int CELLS_W     = 32;

    // B3/S23 rule: born on three, survive on two or three
    localparam int BIRTH_COUNT   = 3;
    localparam int SURVIVE_COUNT = 2;
    localparam int NBR_CNT_W     = 4;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_STEP
    } t_state;

    // Row memory command bundle
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_mem_cmd;

endpackage

[rtl/lag_if.sv]
// ----------------------------------------------------------------------------
// lag_cmd_if / lag_rsp_if
// Valid/ready channels of the grid core: command beats in, read beats out.
// ----------------------------------------------------------------------------
interface lag_cmd_if;
    logic               valid;
    logic               ready;
    lag_pkg::t_op       op;
    logic [4:0]         row_index;
    logic [31:0]        row_cells;

    modport source (output valid, output op, output row_index, output row_cells,
                    input ready);
    modport sink   (input valid, input op, input row_index, input row_cells,
                    output ready);
endinterface

interface lag_rsp_if;
    logic               valid;
    logic               ready;
    logic [31:0]        read_cells;

    modport source (output valid, output read_cells, input ready);
    modport sink   (input valid, input read_cells, output ready);
endinterface

[rtl/life_automaton_grid_core.sv]
// ----------------------------------------------------------------------------
// life_automaton_grid_core
// Square B3/S23 cellular automaton grid held in a row memory, with row
// write, row read, whole-grid step and clear operations.
//
//   channel   dir   beat payload                     results
//   i_cmd     in    op, row_index, row_cells         read gives one beat
//   o_rsp     out   read_cells                       -
//
// Write and clear act on acceptance; read goes through ST_READ, which loads the
// output register (held there while o_rsp stalls, with i_cmd blocked).
// Step sweeps the grid: one memory read per row through a three-row window,
// a write back two rows behind the fetch, and a final row.
// Reset clears every row at once through per-row valid bits.
// ----------------------------------------------------------------------------
module life_automaton_grid_core #(
    parameter int GRID_DIM = lag_pkg::DIM_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lag_cmd_if.sink    i_cmd,
    lag_rsp_if.source  o_rsp
);
    import lag_pkg::*;

    localparam int ADDR_W = $clog2(GRID_DIM);
    localparam int CNT_W  = $clog2(GRID_DIM + 1);
    localparam int IDX_W  = (ADDR_W >= ROW_IDX_W) ? ADDR_W + 1 : ROW_IDX_W + 1;

    t_state              r_state, n_state;
    t_mem_cmd            mem_cmd;
    logic [ADDR_W-1:0]   rd_addr, wr_addr;
    logic [GRID_DIM-1:0] wr_data, rd_data, next_row, below_row;

    logic [IDX_W-1:0]    idx_ext;
    logic                idx_in_range, cmd_acc;

    logic [CNT_W-1:0]    r_rd_row;
    logic [ADDR_W-1:0]   r_wr_row;
    logic                r_arr, r_have_mid, r_rd_hit;
    logic [GRID_DIM-1:0] r_above, r_mid;
    logic                r_out_vld;
    logic [CELLS_W-1:0]  r_out_data;

    logic                step_rd_en, flush, out_load;

    // Decode the command row
    assign idx_ext      = IDX_W'(i_cmd.row_index);
    assign idx_in_range = idx_ext < IDX_W'(GRID_DIM);
    assign cmd_acc      = i_cmd.valid && i_cmd.ready;
    assign i_cmd.ready  = (r_state == ST_IDLE);

    assign step_rd_en = (r_state == ST_STEP) && (r_rd_row != CNT_W'(GRID_DIM));
    assign flush      = (r_state == ST_STEP) && !r_arr && !step_rd_en;
    assign below_row  = r_arr ? rd_data : '0;
    assign out_load   = (r_state == ST_READ) && (!r_out_vld || o_rsp.ready);

    // Hold the controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Select next state and memory commands
    always_comb begin
        n_state = r_state;
        mem_cmd = '0;
        rd_addr = idx_ext[ADDR_W-1:0];
        wr_addr = idx_ext[ADDR_W-1:0];
        wr_data = GRID_DIM'(i_cmd.row_cells);
        unique case (r_state)
            ST_IDLE: begin
                if (cmd_acc) begin
                    unique case (i_cmd.op)
                        OP_WRITE: mem_cmd.wr_en = idx_in_range;
                        OP_READ: begin
                            mem_cmd.rd_en = idx_in_range;
                            n_state       = ST_READ;
                        end
                        OP_STEP: begin
                            mem_cmd.rd_en = 1'b1;
                            rd_addr       = '0;
                            n_state       = ST_STEP;
                        end
                        OP_CLEAR: mem_cmd.clr = 1'b1;
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            ST_STEP: begin
                mem_cmd.rd_en = step_rd_en;
                rd_addr       = r_rd_row[ADDR_W-1:0];
                mem_cmd.wr_en = (r_arr && r_have_mid) || flush;
                wr_addr       = r_wr_row;
                wr_data       = next_row;
                if (flush) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Advance the step sweep and its three-row window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arr      <= 1'b0;
            r_have_mid <= 1'b0;
            r_rd_row   <= '0;
            r_wr_row   <= '0;
        end else if (r_state == ST_IDLE) begin
            r_arr      <= cmd_acc && (i_cmd.op == OP_STEP);
            r_have_mid <= 1'b0;
            r_rd_row   <= CNT_W'(1);
            r_wr_row   <= '0;
        end else if (r_state == ST_STEP) begin
            r_arr <= step_rd_en;
            if (step_rd_en) begin
                r_rd_row <= r_rd_row + CNT_W'(1);
            end
            if (r_arr) begin
                r_have_mid <= 1'b1;
                if (r_have_mid) begin
                    r_wr_row <= r_wr_row + ADDR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_above <= '0;
            r_mid   <= '0;
        end else if (r_state == ST_STEP && r_arr) begin
            r_above <= r_mid;
            r_mid   <= rd_data;
        end
    end

    // Remember whether the read row lies inside the grid
    always_ff @(posedge i_clk) begin
        if (cmd_acc) begin
            r_rd_hit <= idx_in_range;
        end
    end

    // Hold the read beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= r_rd_hit ? CELLS_W'(rd_data) : '0;
        end
    end

    assign o_rsp.valid      = r_out_vld;
    assign o_rsp.read_cells = r_out_data;

    lag_row_mem #(
        .GRID_DIM (GRID_DIM)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (mem_cmd),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    lag_row_update #(
        .GRID_DIM (GRID_DIM)
    ) u_row_update (
        .i_above (r_above),
        .i_mid   (r_mid),
        .i_below (below_row),
        .o_next  (next_row)
    );

`ifndef SYNTHESIS
    // Write back never lands on the row being fetched in the same cycle
    a_step_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_cmd.rd_en && mem_cmd.wr_en) |-> (CNT_W'(wr_addr) != CNT_W'(rd_addr)))
        else $error("step write and read hit the same row");

    // The final write of a step is the last grid row
    a_flush_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flush |-> (r_wr_row == ADDR_W'(GRID_DIM - 1)))
        else $error("step ended on the wrong row");

    // A step always returns to idle after its final row
    a_flush_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        flush |=> (r_state == ST_IDLE))
        else $error("step did not finish");

    // A read beat only appears after a read
    a_out_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> ($past(r_state) == ST_READ))
        else $error("read beat without a read");
`endif

endmodule

[rtl/lag_row_mem.sv]
// ----------------------------------------------------------------------------
// lag_row_mem
// Row store: one grid row per entry, one write and one registered read port.
// Per-row valid bits make unwritten and cleared rows read as all dead.
// ----------------------------------------------------------------------------
module lag_row_mem #(
    parameter int GRID_DIM = lag_pkg::DIM_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lag_pkg::t_mem_cmd             i_cmd,
    input  logic [$clog2(GRID_DIM)-1:0]   i_rd_addr,
    input  logic [$clog2(GRID_DIM)-1:0]   i_wr_addr,
    input  logic [GRID_DIM-1:0]           i_wr_data,
    output logic [GRID_DIM-1:0]           o_rd_data
);
    import lag_pkg::*;

    logic [GRID_DIM-1:0] r_mem [GRID_DIM];
    logic [GRID_DIM-1:0] r_vld;
    logic [GRID_DIM-1:0] r_rd_data;
    logic                r_rd_vld;

    // Write the row array
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Track rows that hold written data; clear drops them all
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clr) begin
            r_vld <= '0;
        end else if (i_cmd.wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Register the read row and its valid bit
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld <= 1'b0;
        end else if (i_cmd.rd_en) begin
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

[rtl/lag_row_update.sv]
// ----------------------------------------------------------------------------
// lag_row_update
// Next generation of one row from the row above, the row itself and the row
// below. Cells past either edge count as dead.
// ----------------------------------------------------------------------------
module lag_row_update #(
    parameter int GRID_DIM = lag_pkg::DIM_DEFAULT
) (
    input  logic [GRID_DIM-1:0] i_above,
    input  logic [GRID_DIM-1:0] i_mid,
    input  logic [GRID_DIM-1:0] i_below,
    output logic [GRID_DIM-1:0] o_next
);
    import lag_pkg::*;

    logic [GRID_DIM-1:0] above_w, above_e, mid_w, mid_e, below_w, below_e;

    // Align west and east neighbors onto each column, zero filled at edges
    assign above_w = i_above << 1;
    assign above_e = i_above >> 1;
    assign mid_w   = i_mid << 1;
    assign mid_e   = i_mid >> 1;
    assign below_w = i_below << 1;
    assign below_e = i_below >> 1;

    // Count live neighbors per column and apply the rule
    always_comb begin
        logic [NBR_CNT_W-1:0] cnt;
        for (int c = 0; c < GRID_DIM; c++) begin
            cnt = NBR_CNT_W'(above_w[c]) + NBR_CNT_W'(i_above[c]) + NBR_CNT_W'(above_e[c])
                + NBR_CNT_W'(mid_w[c]) + NBR_CNT_W'(mid_e[c])
                + NBR_CNT_W'(below_w[c]) + NBR_CNT_W'(i_below[c])
                + NBR_CNT_W'(below_e[c]);
            o_next[c] = (cnt == NBR_CNT_W'(BIRTH_COUNT))
                      || (i_mid[c] && (cnt == NBR_CNT_W'(SURVIVE_COUNT)));
        end
    end

endmodule

[verif/life_grid_checker.sv]
// ----------------------------------------------------------------------------
// life_grid_checker
// Passive checker for the life automaton grid core. It tracks accepted
// command beats, keeps its own copy of the grid and evolves it under
// B3/S23 on every step. Each row read queues the predicted row word, and
// each response beat is compared with the oldest one in the queue.
// ----------------------------------------------------------------------------
module life_grid_checker #(
    parameter int GRID_DIM = lag_pkg::DIM_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lag_cmd_if   i_cmd,
    lag_rsp_if   i_rsp,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_reads_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import lag_pkg::*;

    typedef struct {
        logic [ROW_IDX_W-1:0] row;
        logic [CELLS_W-1:0]   cells;
    } t_row_read;

    logic [GRID_DIM-1:0] grid_rows [GRID_DIM];
    t_row_read           pending_reads [$];

    initial begin
        o_mismatches    = 0;
        o_pending       = 0;
        o_reads_checked = 0;
    end

    // Cells off the grid count as dead
    function automatic int live_at(int r, int c);
        if (r < 0 || r >= GRID_DIM || c < 0 || c >= GRID_DIM) begin
            return 0;
        end
        return int'(grid_rows[r][c]);
    endfunction

    // Advance every cell from the old generation only
    function automatic void next_generation();
        logic [GRID_DIM-1:0] next_rows [GRID_DIM];
        int                  nbrs;
        for (int r = 0; r < GRID_DIM; r++) begin
            next_rows[r] = '0;
            for (int c = 0; c < GRID_DIM; c++) begin
                nbrs = 0;
                for (int dr = -1; dr <= 1; dr++) begin
                    for (int dc = -1; dc <= 1; dc++) begin
                        if (dr != 0 || dc != 0) begin
                            nbrs += live_at(r + dr, c + dc);
                        end
                    end
                end
                if (grid_rows[r][c]) begin
                    next_rows[r][c] = (nbrs == SURVIVE_COUNT || nbrs == BIRTH_COUNT);
                end else begin
                    next_rows[r][c] = (nbrs == BIRTH_COUNT);
                end
            end
        end
        grid_rows = next_rows;
    endfunction

    always @(posedge i_clk) begin
        t_row_read want;
        if (!i_rst_n) begin
            foreach (grid_rows[r]) grid_rows[r] = '0;
            pending_reads.delete();
        end else begin
            // Compare a read beat with the oldest predicted row
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_reads.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: unexpected read beat: expected none, actual %h",
                             $realtime, i_rsp.read_cells);
                end else begin
                    want = pending_reads.pop_front();
                    o_reads_checked++;
                    if (i_rsp.read_cells !== want.cells) begin
                        o_mismatches++;
                        $display("%0t: read_cells of row %0d: expected %h, actual %h",
                                 $realtime, want.row, want.cells, i_rsp.read_cells);
                    end
                end
            end

            // Apply the accepted command beat to the predicted grid
            if (i_cmd.valid && i_cmd.ready) begin
                case (i_cmd.op)
                    OP_WRITE: begin
                        if (i_cmd.row_index < GRID_DIM) begin
                            grid_rows[i_cmd.row_index] = GRID_DIM'(i_cmd.row_cells);
                        end
                    end
                    OP_READ: begin
                        want.row   = i_cmd.row_index;
                        want.cells = (i_cmd.row_index < GRID_DIM)
                                   ? CELLS_W'(grid_rows[i_cmd.row_index]) : '0;
                        pending_reads.push_back(want);
                    end
                    OP_STEP: begin
                        next_generation();
                    end
                    OP_CLEAR: begin
                        foreach (grid_rows[r]) grid_rows[r] = '0;
                    end
                    default: ;
                endcase
            end
        end
        o_pending = pending_reads.size();
    end

endmodule

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Top of the life automaton grid testbench. Drives command beats into the
// grid core, stalls the read channel at random and gives the verdict from
// the checker's mismatch count. Stimulus opens with edge rows, edge columns
// and blinkers on the border, then runs random seed/evolve/inspect episodes.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lag_pkg::*;

    localparam int GRID_DIM       = DIM_DEFAULT;
    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 8;
    localparam int TOTAL_BEATS    = 1950;
    localparam int DRAIN_CYCLES   = GRID_DIM + 8;
    localparam int CYCLE_LIMIT    = 1_000_000;

    logic i_clk;
    logic i_rst_n;

    lag_cmd_if cmd_ch ();
    lag_rsp_if rsp_ch ();

    int mismatch_count;
    int reads_pending;
    int reads_checked;
    int beats_sent;
    int n_writes;
    int n_reads;
    int n_steps;
    int n_clears;
    int cycle_count;
    bit quiet_stretch;

    life_automaton_grid_core #(.GRID_DIM(GRID_DIM)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_rsp   (rsp_ch)
    );

    life_grid_checker #(.GRID_DIM(GRID_DIM)) grid_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd_ch),
        .i_rsp           (rsp_ch),
        .o_mismatches    (mismatch_count),
        .o_pending       (reads_pending),
        .o_reads_checked (reads_checked)
    );

    always begin
        i_clk = 1'b0;
        #(HALF_PERIOD);
        i_clk = 1'b1;
        #(HALF_PERIOD);
    end

    // Mostly short gaps, a few long ones, none during a quiet stretch
    function automatic int idle_len();
        int pick;
        if (quiet_stretch) begin
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            return 0;
        end
        if (pick < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 40);
    endfunction

    // Row contents from empty through sparse and dense to full
    function automatic logic [CELLS_W-1:0] seed_word();
        case ($urandom_range(0, 7))
            0:       return $urandom() & $urandom() & $urandom();
            1:       return $urandom() & $urandom();
            2:       return $urandom();
            3:       return $urandom() | $urandom();
            4:       return CELLS_W'(7) << $urandom_range(0, CELLS_W - 3);
            5:       return '1;
            6:       return '0;
            default: return $urandom() & $urandom();
        endcase
    endfunction

    // Drive one command beat and hold it until the core takes it
    task automatic put_beat(t_op op, logic [ROW_IDX_W-1:0] row, logic [CELLS_W-1:0] cells);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.op        <= op;
        cmd_ch.row_index <= row;
        cmd_ch.row_cells <= cells;
        @(negedge i_clk);
        while (!cmd_ch.ready) @(negedge i_clk);
        @(posedge i_clk);
        beats_sent++;
        case (op)
            OP_WRITE: n_writes++;
            OP_READ:  n_reads++;
            OP_STEP:  n_steps++;
            default:  n_clears++;
        endcase
    endtask

    // Seed a pattern, evolve it a few generations and inspect rows
    task automatic run_episode();
        int n_band;
        int band_top;
        int n_gens;
        quiet_stretch = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 2) == 0) begin
            put_beat(OP_CLEAR, ROW_IDX_W'($urandom()), $urandom());
        end
        n_band   = $urandom_range(0, 10);
        band_top = $urandom_range(0, GRID_DIM - 1);
        for (int i = 0; i < n_band; i++) begin
            put_beat(OP_WRITE, ROW_IDX_W'((band_top + i) % GRID_DIM), seed_word());
        end
        repeat ($urandom_range(0, 4)) begin
            put_beat(OP_WRITE, ROW_IDX_W'($urandom()), seed_word());
        end
        n_gens = $urandom_range(1, 5);
        for (int g = 0; g < n_gens; g++) begin
            put_beat(OP_STEP, ROW_IDX_W'($urandom()), $urandom());
            if ($urandom_range(0, 7) == 0) begin
                for (int r = 0; r < GRID_DIM; r++) begin
                    put_beat(OP_READ, ROW_IDX_W'(r), $urandom());
                end
            end else begin
                repeat ($urandom_range(0, 6)) begin
                    put_beat(OP_READ, ROW_IDX_W'($urandom()), $urandom());
                end
            end
        end
        // Sprinkle fully random beats
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 4)) begin
                put_beat(t_op'($urandom_range(0, 3)), ROW_IDX_W'($urandom()), $urandom());
            end
        end
    endtask

    // Stall the read channel at random
    initial begin : read_backpressure
        int hold;
        rsp_ch.ready <= 1'b1;
        forever begin
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            hold = idle_len();
            if (hold > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Abort a hung run
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timed out after %0d cycles with %0d reads outstanding",
                 cycle_count, reads_pending);
        $display("FAILED: results differ");
        $finish;
    end

    initial begin : stimulus
        beats_sent        = 0;
        n_writes          = 0;
        n_reads           = 0;
        n_steps           = 0;
        n_clears          = 0;
        quiet_stretch     = 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.op        <= OP_WRITE;
        cmd_ch.row_index <= '0;
        cmd_ch.row_cells <= '0;
        i_rst_n          <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty grid after reset, then edge rows and columns
        put_beat(OP_READ,  ROW_IDX_W'(0),            $urandom());
        put_beat(OP_READ,  ROW_IDX_W'(GRID_DIM - 1), $urandom());
        put_beat(OP_WRITE, ROW_IDX_W'(0),            '1);
        put_beat(OP_WRITE, ROW_IDX_W'(GRID_DIM - 1), 32'h8000_0001);
        // Blinkers against the left and right borders
        put_beat(OP_WRITE, ROW_IDX_W'(15),           32'h0000_0007);
        put_beat(OP_WRITE, ROW_IDX_W'(17),           32'hE000_0000);
        put_beat(OP_READ,  ROW_IDX_W'(0),            $urandom());
        put_beat(OP_READ,  ROW_IDX_W'(GRID_DIM - 1), $urandom());
        put_beat(OP_STEP,  '1,                       '1);
        put_beat(OP_READ,  ROW_IDX_W'(0),            $urandom());
        put_beat(OP_READ,  ROW_IDX_W'(1),            $urandom());
        put_beat(OP_READ,  ROW_IDX_W'(14),           $urandom());
        put_beat(OP_READ,  ROW_IDX_W'(16),           $urandom());
        put_beat(OP_READ,  ROW_IDX_W'(17),           $urandom());
        put_beat(OP_READ,  ROW_IDX_W'(GRID_DIM - 2), $urandom());
        put_beat(OP_READ,  ROW_IDX_W'(GRID_DIM - 1), $urandom());
        put_beat(OP_STEP,  '0,                       '0);
        put_beat(OP_READ,  ROW_IDX_W'(15),           $urandom());
        put_beat(OP_CLEAR, ROW_IDX_W'($urandom()),   $urandom());
        put_beat(OP_READ,  ROW_IDX_W'(0),            $urandom());
        put_beat(OP_READ,  ROW_IDX_W'(15),           $urandom());
        // Step of an empty grid stays empty
        put_beat(OP_STEP,  ROW_IDX_W'($urandom()),   $urandom());
        put_beat(OP_READ,  ROW_IDX_W'(GRID_DIM - 1), $urandom());

        while (beats_sent < TOTAL_BEATS) begin
            run_episode();
        end
        cmd_ch.valid <= 1'b0;
        quiet_stretch = 1'b0;

        // Drain outstanding reads, then leave time for a step to finish
        @(negedge i_clk);
        while (reads_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d row writes, %0d row reads, %0d generation steps, %0d clears",
                 n_writes, n_reads, n_steps, n_clears);
        $display("Compared %0d read beats against the predicted grid, %0d mismatches",
                 reads_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
